[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the record stream parser RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ARSP_ASSERT_RST(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");
`define ARSP_ASSERT(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed");
`else
`define ARSP_ASSERT_RST(label, clk, rstn, prop)
`define ARSP_ASSERT(label, clk, prop)
`endif
`endif

[hw/rtl/arsp_pkg.sv]
// ----------------------------------------------------------------------------
// arsp_pkg
// Types and codes shared by the attribute record stream parser modules.
// ----------------------------------------------------------------------------
package arsp_pkg;

    localparam int unsigned LimitW = 30;
    localparam logic [LimitW-1:0] LimitReset = 30'h3fffffff;

    typedef enum logic [3:0] {
        EV_GEN      = 4'd0,
        EV_TYPE     = 4'd1,
        EV_KIND     = 4'd2,
        EV_BOOL     = 4'd3,
        EV_INT      = 4'd4,
        EV_LEN      = 4'd5,
        EV_STR_BYTE = 4'd6,
        EV_MECH     = 4'd7,
        EV_ERR      = 4'd8,
        EV_END      = 4'd9
    } ev_code_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_EMPTY     = 3'd1,
        ST_TRUNC     = 3'd2,
        ST_BAD_KIND  = 3'd3,
        ST_OVER_MAX  = 3'd4,
        ST_OVERRUN   = 3'd5,
        ST_MAP_IN_MAP = 3'd6
    } status_t;

    localparam logic [2:0] REC_BOOL = 3'd1;
    localparam logic [2:0] REC_INT  = 3'd2;
    localparam logic [2:0] REC_STR  = 3'd3;
    localparam logic [2:0] REC_MAP  = 3'd4;
    localparam logic [2:0] REC_MECH = 3'd5;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
    } item_t;

    typedef struct packed {
        ev_code_t    ev;
        logic [63:0] value;
        logic        nested;
        logic        type_wide;
        status_t     status;
    } result_t;

endpackage

[hw/rtl/arsp_in_stage.sv]
// ----------------------------------------------------------------------------
// arsp_in_stage
// Input register: holds one accepted item until the parser consumes it.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module arsp_in_stage (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  arsp_pkg::item_t  s_item,
    input  logic             out_space,
    output logic             item_valid,
    output logic             advance,
    output arsp_pkg::item_t  item
);

    logic            valid_reg;
    logic            valid_next;
    arsp_pkg::item_t item_reg;
    arsp_pkg::item_t item_next;

    assign advance = valid_reg && out_space;
    assign s_ready = !valid_reg || advance;
    assign item_valid = valid_reg;
    assign item = item_reg;

    always_comb begin
        valid_next = valid_reg;
        item_next = item_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
            item_next = s_item;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        item_reg <= item_next;
    end

    `ARSP_ASSERT(a_reset_empties, aclk, !aresetn |=> !valid_reg)

endmodule

[hw/rtl/arsp_parser.sv]
// ----------------------------------------------------------------------------
// arsp_parser
// Parse state and the combinational step that turns one item into at most one event.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module arsp_parser (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [arsp_pkg::LimitW-1:0]   cfg_wdata,
    input  logic                          step_en,
    input  arsp_pkg::item_t               item,
    output logic                          res_valid,
    output arsp_pkg::result_t             res
);

    typedef enum logic [3:0] {
        PH_GEN,
        PH_TYPE,
        PH_KIND,
        PH_BOOL,
        PH_ULONG,
        PH_BLEN,
        PH_STR,
        PH_MLEN,
        PH_CNT,
        PH_MECH,
        PH_ERR
    } phase_t;

    phase_t                        phase_reg;
    phase_t                        phase_next;
    logic                          nest_reg;
    logic                          nest_next;
    logic [2:0]                    byte_idx_reg;
    logic [2:0]                    byte_idx_next;
    logic [55:0]                   asm_reg;
    logic [55:0]                   asm_next;
    logic [arsp_pkg::LimitW-1:0]   rem_reg;
    logic [arsp_pkg::LimitW-1:0]   rem_next;
    logic [arsp_pkg::LimitW-1:0]   inner_reg;
    logic [arsp_pkg::LimitW-1:0]   inner_next;
    arsp_pkg::status_t             err_reg;
    arsp_pkg::status_t             err_next;
    logic [arsp_pkg::LimitW-1:0]   max_len_reg;

    logic                          need8;
    logic [arsp_pkg::LimitW-1:0]   inner_after;
    logic [63:0]                   fld;
    logic                          done_nest;
    logic                          over_max;
    logic                          over_inner;
    logic                          over_inner8;
    logic                          kind_bad;
    logic                          fail;
    arsp_pkg::status_t             fail_st;

    assign need8 = (phase_reg != PH_BOOL) && (phase_reg != PH_STR);
    assign inner_after = nest_reg ? inner_reg - 30'd1 : inner_reg;
    assign fld = need8 ? {asm_reg, item.data_byte} : {56'd0, item.data_byte};
    assign done_nest = nest_reg && (inner_after != '0);
    assign over_max = (fld[63:30] != '0) || (fld[29:0] > max_len_reg);
    assign over_inner = (fld[63:30] != '0) || (fld[29:0] > inner_after);
    assign over_inner8 = (fld[63:27] != '0) || (fld[26:0] > inner_after[29:3]);
    assign kind_bad = (fld[63:3] != '0) || (fld[2:0] == 3'd0) || (fld[2:0] > arsp_pkg::REC_MECH);

    always_comb begin
        phase_next = phase_reg;
        nest_next = nest_reg;
        byte_idx_next = byte_idx_reg;
        asm_next = asm_reg;
        rem_next = rem_reg;
        inner_next = inner_reg;
        err_next = err_reg;
        res_valid = 1'b0;
        res.ev = arsp_pkg::EV_GEN;
        res.value = '0;
        res.nested = 1'b0;
        res.type_wide = 1'b0;
        res.status = arsp_pkg::ST_OK;
        fail = 1'b0;
        fail_st = arsp_pkg::ST_OK;
        if (step_en) begin
            if (item.kind) begin
                res_valid = 1'b1;
                res.ev = arsp_pkg::EV_END;
                if (err_reg != arsp_pkg::ST_OK) begin
                    res.status = err_reg;
                end else if (phase_reg == PH_GEN) begin
                    res.status = arsp_pkg::ST_EMPTY;
                end else if (phase_reg == PH_TYPE && !nest_reg && byte_idx_reg == 3'd0) begin
                    res.status = arsp_pkg::ST_OK;
                end else begin
                    res.status = arsp_pkg::ST_TRUNC;
                end
                phase_next = PH_GEN;
                nest_next = 1'b0;
                byte_idx_next = '0;
                asm_next = '0;
                rem_next = '0;
                inner_next = '0;
                err_next = arsp_pkg::ST_OK;
            end else if (phase_reg != PH_ERR) begin
                if (nest_reg && byte_idx_reg == 3'd0 &&
                    (need8 ? (inner_reg < 30'd8) : (inner_reg == '0))) begin
                    fail = 1'b1;
                    fail_st = arsp_pkg::ST_OVERRUN;
                end else begin
                    inner_next = inner_after;
                    if (need8 && byte_idx_reg != 3'd7) begin
                        byte_idx_next = byte_idx_reg + 3'd1;
                        asm_next = {asm_reg[47:0], item.data_byte};
                    end else begin
                        byte_idx_next = '0;
                        asm_next = '0;
                        res_valid = 1'b1;
                        res.value = fld;
                        res.nested = nest_reg;
                        case (phase_reg)
                            PH_GEN: begin
                                phase_next = PH_TYPE;
                                res.ev = arsp_pkg::EV_GEN;
                            end
                            PH_TYPE: begin
                                phase_next = PH_KIND;
                                res.ev = arsp_pkg::EV_TYPE;
                                res.type_wide = (fld[63:32] != '0);
                            end
                            PH_KIND: begin
                                res.ev = arsp_pkg::EV_KIND;
                                if (kind_bad) begin
                                    fail = 1'b1;
                                    fail_st = arsp_pkg::ST_BAD_KIND;
                                end else if (nest_reg && fld[2:0] == arsp_pkg::REC_MAP) begin
                                    fail = 1'b1;
                                    fail_st = arsp_pkg::ST_MAP_IN_MAP;
                                end else begin
                                    case (fld[2:0])
                                        arsp_pkg::REC_BOOL: phase_next = PH_BOOL;
                                        arsp_pkg::REC_INT:  phase_next = PH_ULONG;
                                        arsp_pkg::REC_STR:  phase_next = PH_BLEN;
                                        arsp_pkg::REC_MAP:  phase_next = PH_MLEN;
                                        default:            phase_next = PH_CNT;
                                    endcase
                                end
                            end
                            PH_BOOL: begin
                                res.ev = arsp_pkg::EV_BOOL;
                                phase_next = PH_TYPE;
                                nest_next = done_nest;
                            end
                            PH_ULONG: begin
                                res.ev = arsp_pkg::EV_INT;
                                phase_next = PH_TYPE;
                                nest_next = done_nest;
                            end
                            PH_BLEN, PH_CNT: begin
                                res.ev = arsp_pkg::EV_LEN;
                                if (!nest_reg && over_max) begin
                                    fail = 1'b1;
                                    fail_st = arsp_pkg::ST_OVER_MAX;
                                end else if (nest_reg &&
                                             (phase_reg == PH_BLEN ? over_inner : over_inner8)) begin
                                    fail = 1'b1;
                                    fail_st = arsp_pkg::ST_OVERRUN;
                                end else if (fld == '0) begin
                                    phase_next = PH_TYPE;
                                    nest_next = done_nest;
                                end else begin
                                    rem_next = fld[29:0];
                                    phase_next = (phase_reg == PH_BLEN) ? PH_STR : PH_MECH;
                                end
                            end
                            PH_STR, PH_MECH: begin
                                res.ev = (phase_reg == PH_STR) ? arsp_pkg::EV_STR_BYTE
                                                               : arsp_pkg::EV_MECH;
                                if (rem_reg != '0) begin
                                    rem_next = rem_reg - 30'd1;
                                end
                                if (rem_reg <= 30'd1) begin
                                    phase_next = PH_TYPE;
                                    nest_next = done_nest;
                                end
                            end
                            PH_MLEN: begin
                                res.ev = arsp_pkg::EV_LEN;
                                res.nested = 1'b0;
                                if (over_max) begin
                                    fail = 1'b1;
                                    fail_st = arsp_pkg::ST_OVER_MAX;
                                end else begin
                                    inner_next = fld[29:0];
                                    phase_next = PH_TYPE;
                                    nest_next = (fld != '0);
                                end
                            end
                            default: begin
                                fail = 1'b1;
                                fail_st = arsp_pkg::ST_TRUNC;
                            end
                        endcase
                    end
                end
                if (fail) begin
                    phase_next = PH_ERR;
                    nest_next = 1'b0;
                    err_next = fail_st;
                    byte_idx_next = '0;
                    asm_next = '0;
                    res_valid = 1'b1;
                    res.ev = arsp_pkg::EV_ERR;
                    res.value = '0;
                    res.nested = nest_reg;
                    res.type_wide = 1'b0;
                    res.status = fail_st;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_GEN;
            nest_reg <= 1'b0;
            byte_idx_reg <= '0;
            asm_reg <= '0;
            rem_reg <= '0;
            inner_reg <= '0;
            err_reg <= arsp_pkg::ST_OK;
            max_len_reg <= arsp_pkg::LimitReset;
        end else begin
            phase_reg <= phase_next;
            nest_reg <= nest_next;
            byte_idx_reg <= byte_idx_next;
            asm_reg <= asm_next;
            rem_reg <= rem_next;
            inner_reg <= inner_next;
            err_reg <= err_next;
            if (cfg_we) begin
                max_len_reg <= cfg_wdata;
            end
        end
    end

    `ARSP_ASSERT_RST(a_err_latched, aclk, aresetn, (phase_reg == PH_ERR) |-> (err_reg != arsp_pkg::ST_OK))
    `ARSP_ASSERT_RST(a_nest_phase, aclk, aresetn, nest_reg |-> (phase_reg != PH_GEN && phase_reg != PH_MLEN && phase_reg != PH_ERR))
    `ARSP_ASSERT_RST(a_mid_field, aclk, aresetn, (byte_idx_reg != 3'd0) |-> (phase_reg != PH_BOOL && phase_reg != PH_STR && phase_reg != PH_ERR))
    `ARSP_ASSERT_RST(a_end_rearms, aclk, aresetn, (step_en && item.kind) |=> (phase_reg == PH_GEN && !nest_reg && err_reg == arsp_pkg::ST_OK))

endmodule

[hw/rtl/arsp_out_stage.sv]
// ----------------------------------------------------------------------------
// arsp_out_stage
// Result register: holds one event until the downstream side takes it.
// ----------------------------------------------------------------------------
module arsp_out_stage (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               load,
    input  arsp_pkg::result_t  res,
    output logic               out_space,
    output logic               m_valid,
    input  logic               m_ready,
    output arsp_pkg::result_t  m_res
);

    logic              valid_reg;
    logic              valid_next;
    arsp_pkg::result_t res_reg;
    arsp_pkg::result_t res_next;

    assign out_space = !valid_reg || m_ready;
    assign m_valid = valid_reg;
    assign m_res = res_reg;

    always_comb begin
        valid_next = valid_reg;
        res_next = res_reg;
        if (load) begin
            valid_next = 1'b1;
            res_next = res;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        res_reg <= res_next;
    end

endmodule

[hw/rtl/attribute_record_stream_parser_core.sv]
// ----------------------------------------------------------------------------
// attribute_record_stream_parser_core
// Byte-serial parser for attribute record object files, one event per field.
// ----------------------------------------------------------------------------
// The core takes one transfer per clock unless the downstream side stalls: a
// file byte, or an end marker that reports the final status and rearms the
// parser. Each transfer passes through an input register, a combinational
// parse step and a result register, which holds the result until it is taken.
// Bytes that only add to a multi-byte field, and bytes after an error, give no
// result.
// There is no clearing pass after reset.
module attribute_record_stream_parser_core (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [29:0]  cfg_wdata,
    input  logic         s_valid,
    output logic         s_ready,
    input  logic         s_kind,
    input  logic [7:0]   s_data_byte,
    output logic         m_valid,
    input  logic         m_ready,
    output logic [3:0]   m_event_res,
    output logic [63:0]  m_value,
    output logic         m_nested,
    output logic         m_type_wide,
    output logic [2:0]   m_status
);

    arsp_pkg::item_t   s_item;
    arsp_pkg::item_t   item;
    arsp_pkg::result_t res;
    arsp_pkg::result_t m_res;
    logic              item_valid;
    logic              advance;
    logic              out_space;
    logic              res_valid;

    assign s_item.kind = s_kind;
    assign s_item.data_byte = s_data_byte;

    arsp_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .out_space  (out_space),
        .item_valid (item_valid),
        .advance    (advance),
        .item       (item)
    );

    arsp_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .step_en   (advance && item_valid),
        .item      (item),
        .res_valid (res_valid),
        .res       (res)
    );

    arsp_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (res_valid),
        .res       (res),
        .out_space (out_space),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_res     (m_res)
    );

    assign m_event_res = m_res.ev;
    assign m_value = m_res.value;
    assign m_nested = m_res.nested;
    assign m_type_wide = m_res.type_wide;
    assign m_status = m_res.status;

endmodule

[test/tb_attribute_record_stream_parser_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_attribute_record_stream_parser_core
// Self-checking testbench for the attribute record stream parser core.
// A short table of directed transfers is followed by randomly built object
// files, mostly well formed with random content and some truncated, broken
// or pure noise. Every accepted byte is run through a behavioural parser in
// the testbench, and each event from the core is checked field by field
// against the oldest prediction, under several idling patterns and limits.
// ----------------------------------------------------------------------------
module tb_attribute_record_stream_parser_core;

    localparam int unsigned SETTLE_CYCLES   = 8;
    localparam int unsigned HOLD_CYCLES     = 300;
    localparam int unsigned WATCHDOG_LIMIT  = 2000;
    localparam int unsigned MAX_REPORTS     = 100;
    localparam int unsigned ITEMS_PER_PHASE = 90;

    typedef enum logic [3:0] {
        PH_GEN, PH_TYPE, PH_KIND, PH_BOOL, PH_INT, PH_SLEN, PH_STR,
        PH_MLEN, PH_CNT, PH_MECH, PH_ERR
    } parse_phase_t;

    typedef struct {
        arsp_pkg::item_t   item;
        bit                pinned;
        arsp_pkg::result_t want;
    } stim_row_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [29:0] cfg_wdata;
    logic        s_valid;
    logic        s_ready;
    logic        s_kind;
    logic [7:0]  s_data_byte;
    logic        m_valid;
    logic        m_ready;
    logic [3:0]  m_event_res;
    logic [63:0] m_value;
    logic        m_nested;
    logic        m_type_wide;
    logic [2:0]  m_status;

    // Behavioural parser state
    parse_phase_t      ph;
    bit                in_map;
    int unsigned       byte_idx;
    logic [63:0]       acc;
    logic [63:0]       rec_left;
    logic [63:0]       budget_left;
    arsp_pkg::status_t sticky_status;
    logic [29:0]       limit_reg;

    arsp_pkg::result_t expected_events[$];
    stim_row_t         sent_rows[$];
    stim_row_t         directed_rows[$];
    int unsigned       mismatch_count = 0;
    int unsigned       useful_items = 0;
    int unsigned       quiet_cycles = 0;
    int unsigned       gap_pct = 0;
    int unsigned       stall_pct = 0;
    bit                hold_req = 1'b0;

    attribute_record_stream_parser_core dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_kind      (s_kind),
        .s_data_byte (s_data_byte),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_event_res (m_event_res),
        .m_value     (m_value),
        .m_nested    (m_nested),
        .m_type_wide (m_type_wide),
        .m_status    (m_status)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic void clear_parser();
        ph = PH_GEN;
        in_map = 1'b0;
        byte_idx = 0;
        acc = '0;
        rec_left = '0;
        budget_left = '0;
        sticky_status = arsp_pkg::ST_OK;
    endfunction

    function automatic void close_record();
        in_map = in_map && (budget_left != 0);
        ph = PH_TYPE;
    endfunction

    function automatic bit fail_parse(inout arsp_pkg::result_t r,
                                      input arsp_pkg::status_t code);
        r.ev = arsp_pkg::EV_ERR;
        r.value = '0;
        r.nested = in_map;
        r.type_wide = 1'b0;
        r.status = code;
        sticky_status = code;
        ph = PH_ERR;
        in_map = 1'b0;
        byte_idx = 0;
        acc = '0;
        return 1'b1;
    endfunction

    function automatic bit predict_event(input logic is_end, input logic [7:0] b,
                                         output arsp_pkg::result_t r);
        logic [63:0] v;
        int unsigned need;
        r = '0;
        r.ev = arsp_pkg::EV_END;
        if (is_end) begin
            if (sticky_status != arsp_pkg::ST_OK) r.status = sticky_status;
            else if (ph == PH_GEN) r.status = arsp_pkg::ST_EMPTY;
            else if (ph == PH_TYPE && !in_map && byte_idx == 0) r.status = arsp_pkg::ST_OK;
            else r.status = arsp_pkg::ST_TRUNC;
            clear_parser();
            return 1'b1;
        end
        if (ph == PH_ERR) return 1'b0;
        need = (ph == PH_BOOL || ph == PH_STR) ? 1 : 8;
        if (in_map) begin
            if (byte_idx == 0 && budget_left < need)
                return fail_parse(r, arsp_pkg::ST_OVERRUN);
            budget_left--;
        end
        v = {56'h0, b};
        if (need == 8) begin
            acc = {acc[55:0], b};
            if (byte_idx < 7) begin
                byte_idx++;
                return 1'b0;
            end
            byte_idx = 0;
            v = acc;
            acc = '0;
        end
        r.value = v;
        r.nested = in_map;
        case (ph)
            PH_GEN: begin
                r.ev = arsp_pkg::EV_GEN;
                ph = PH_TYPE;
            end
            PH_TYPE: begin
                r.ev = arsp_pkg::EV_TYPE;
                r.type_wide = (v[63:32] != 0);
                ph = PH_KIND;
            end
            PH_KIND: begin
                if (v < arsp_pkg::REC_BOOL || v > arsp_pkg::REC_MECH)
                    return fail_parse(r, arsp_pkg::ST_BAD_KIND);
                if (in_map && v == arsp_pkg::REC_MAP)
                    return fail_parse(r, arsp_pkg::ST_MAP_IN_MAP);
                r.ev = arsp_pkg::EV_KIND;
                case (v[2:0])
                    arsp_pkg::REC_BOOL: ph = PH_BOOL;
                    arsp_pkg::REC_INT:  ph = PH_INT;
                    arsp_pkg::REC_STR:  ph = PH_SLEN;
                    arsp_pkg::REC_MAP:  ph = PH_MLEN;
                    default:            ph = PH_CNT;
                endcase
            end
            PH_BOOL, PH_INT: begin
                r.ev = (ph == PH_BOOL) ? arsp_pkg::EV_BOOL : arsp_pkg::EV_INT;
                close_record();
            end
            PH_SLEN, PH_CNT: begin
                if (!in_map && v > limit_reg) return fail_parse(r, arsp_pkg::ST_OVER_MAX);
                if (in_map && v > ((ph == PH_SLEN) ? budget_left : (budget_left >> 3)))
                    return fail_parse(r, arsp_pkg::ST_OVERRUN);
                r.ev = arsp_pkg::EV_LEN;
                if (v == 0) begin
                    close_record();
                end else begin
                    rec_left = v;
                    ph = (ph == PH_SLEN) ? PH_STR : PH_MECH;
                end
            end
            PH_STR, PH_MECH: begin
                r.ev = (ph == PH_STR) ? arsp_pkg::EV_STR_BYTE : arsp_pkg::EV_MECH;
                if (rec_left != 0) rec_left--;
                if (rec_left == 0) close_record();
            end
            PH_MLEN: begin
                if (v > limit_reg) return fail_parse(r, arsp_pkg::ST_OVER_MAX);
                r.ev = arsp_pkg::EV_LEN;
                budget_left = v;
                in_map = (v != 0);
                ph = PH_TYPE;
            end
            default: return fail_parse(r, arsp_pkg::ST_TRUNC);
        endcase
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%0t: %s mismatch, got 0x%0h expected 0x%0h", $time, field, got, want);
    endtask

    always @(posedge aclk) begin : scoreboard
        arsp_pkg::result_t predicted;
        arsp_pkg::result_t want;
        stim_row_t         row;
        bit                produced;
        if (!aresetn) begin
            clear_parser();
            limit_reg = arsp_pkg::LimitReset;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_events.size() == 0) begin
                    report_mismatch("unexpected event", 64'(m_event_res), '0);
                end else begin
                    want = expected_events.pop_front();
                    if (m_event_res !== want.ev)
                        report_mismatch("event", 64'(m_event_res), 64'(want.ev));
                    if (m_value !== want.value)
                        report_mismatch("value", m_value, want.value);
                    if (m_nested !== want.nested)
                        report_mismatch("nested", 64'(m_nested), 64'(want.nested));
                    if (m_type_wide !== want.type_wide)
                        report_mismatch("type_wide", 64'(m_type_wide), 64'(want.type_wide));
                    if (m_status !== want.status)
                        report_mismatch("status", 64'(m_status), 64'(want.status));
                end
            end
            if (cfg_we) limit_reg = cfg_wdata;
            if (s_valid && s_ready) begin
                if (s_kind || ph != PH_ERR) useful_items++;
                produced = predict_event(s_kind, s_data_byte, predicted);
                row = sent_rows.pop_front();
                if (row.pinned) expected_events.insert(expected_events.size(), row.want);
                else if (produced) expected_events.insert(expected_events.size(), predicted);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no transfer for %0d cycles", quiet_cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // The receiver stalls at random, and holds off completely on request so
    // that the core fills up and pushes back on the sender.
    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    function automatic void add_row(input logic is_end, input logic [7:0] b, input bit pinned,
                                    input arsp_pkg::ev_code_t ev, input logic [63:0] val,
                                    input arsp_pkg::status_t st);
        stim_row_t row;
        row.item.kind = is_end;
        row.item.data_byte = b;
        row.pinned = pinned;
        row.want = '0;
        row.want.ev = ev;
        row.want.value = val;
        row.want.status = st;
        directed_rows.insert(directed_rows.size(), row);
    endfunction

    function automatic void push_byte(ref arsp_pkg::item_t q[$], input logic [7:0] b);
        arsp_pkg::item_t it;
        it.kind = 1'b0;
        it.data_byte = b;
        q.insert(q.size(), it);
    endfunction

    function automatic void push_field(ref arsp_pkg::item_t q[$], input logic [63:0] v);
        for (int i = 7; i >= 0; i--) push_byte(q, v[i*8 +: 8]);
    endfunction

    function automatic void push_end(ref arsp_pkg::item_t q[$]);
        arsp_pkg::item_t it;
        it.kind = 1'b1;
        it.data_byte = $urandom_range(255);
        q.insert(q.size(), it);
    endfunction

    function automatic logic [63:0] pick_count(input logic [29:0] lim);
        case ($urandom_range(19))
            0: return {$urandom, $urandom};
            1: return 64'(lim);
            2: return 64'(lim) + 64'd1;
            default: return 64'($urandom_range(6));
        endcase
    endfunction

    function automatic void add_record(ref arsp_pkg::item_t q[$], input bit nested_rec,
                                       input logic [29:0] lim);
        arsp_pkg::item_t inner[$];
        logic [63:0]     kind_v;
        logic [63:0]     cnt;
        int unsigned     sel;
        int unsigned     n;
        case ($urandom_range(3))
            0: push_field(q, {32'h0, $urandom});
            1: push_field(q, {$urandom, $urandom});
            2: push_field(q, 64'h1_0000_0000);
            default: push_field(q, 64'hffff_ffff);
        endcase
        sel = $urandom_range(99);
        if (sel < 18) kind_v = 64'(arsp_pkg::REC_BOOL);
        else if (sel < 36) kind_v = 64'(arsp_pkg::REC_INT);
        else if (sel < 56) kind_v = 64'(arsp_pkg::REC_STR);
        else if (sel < 72) kind_v = 64'(arsp_pkg::REC_MECH);
        else if (sel < (nested_rec ? 75 : 92)) kind_v = 64'(arsp_pkg::REC_MAP);
        else if (sel < 92) kind_v = 64'(arsp_pkg::REC_INT);
        else begin
            case ($urandom_range(2))
                0: kind_v = '0;
                1: kind_v = 64'($urandom_range(255, 6));
                default: kind_v = {$urandom | 32'h1, $urandom};
            endcase
        end
        push_field(q, kind_v);
        if (kind_v == arsp_pkg::REC_BOOL) begin
            push_byte(q, $urandom_range(255));
        end else if (kind_v == arsp_pkg::REC_INT) begin
            push_field(q, {$urandom, $urandom});
        end else if (kind_v == arsp_pkg::REC_STR || kind_v == arsp_pkg::REC_MECH) begin
            cnt = pick_count(lim);
            push_field(q, cnt);
            n = (cnt <= 8) ? int'(cnt[3:0]) : $urandom_range(3);
            repeat (n) begin
                if (kind_v == arsp_pkg::REC_STR) push_byte(q, $urandom_range(255));
                else push_field(q, {$urandom, $urandom});
            end
        end else if (kind_v == arsp_pkg::REC_MAP && !nested_rec) begin
            repeat ($urandom_range(3)) add_record(inner, 1'b1, lim);
            cnt = inner.size();
            case ($urandom_range(9))
                0: cnt = cnt + $urandom_range(9, 1);
                1: if (cnt != 0) cnt = cnt - $urandom_range(int'(cnt), 1);
                2: cnt = {$urandom, $urandom};
                default: ;
            endcase
            push_field(q, cnt);
            foreach (inner[i]) q.insert(q.size(), inner[i]);
        end
    endfunction

    function automatic void add_file(ref arsp_pkg::item_t q[$], input logic [29:0] lim);
        arsp_pkg::item_t body[$];
        int unsigned     sel;
        int unsigned     keep;
        sel = $urandom_range(19);
        if (sel == 0) begin
            repeat ($urandom_range(12, 1)) push_byte(body, $urandom_range(255));
        end else begin
            push_field(body, {$urandom, $urandom});
            repeat ($urandom_range(4)) add_record(body, 1'b0, lim);
            if (sel <= 3) begin
                keep = $urandom_range(body.size());
                while (body.size() > keep) void'(body.pop_back());
            end
        end
        foreach (body[i]) q.insert(q.size(), body[i]);
        push_end(q);
    endfunction

    task automatic send_item(input stim_row_t row);
        while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        sent_rows.insert(sent_rows.size(), row);
        s_valid <= 1'b1;
        s_kind <= row.item.kind;
        s_data_byte <= row.item.data_byte;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_file(ref arsp_pkg::item_t q[$]);
        stim_row_t row;
        row.pinned = 1'b0;
        row.want = '0;
        foreach (q[i]) begin
            row.item = q[i];
            send_item(row);
        end
    endtask

    // The limit register is only written once the core has gone quiet.
    task automatic write_limit(input logic [29:0] val);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_events.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    initial begin : stimulus
        arsp_pkg::item_t file_q[$];
        logic [29:0]     lim;
        int unsigned     target;
        aresetn <= 1'b0;
        cfg_we <= 1'b0;
        cfg_wdata <= '0;
        s_valid <= 1'b0;
        s_kind <= 1'b0;
        s_data_byte <= '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        add_row(1'b1, 8'h00, 1'b1, arsp_pkg::EV_END, '0, arsp_pkg::ST_EMPTY);
        for (int i = 0; i < 3; i++)
            add_row(1'b0, 8'h5a, 1'b0, arsp_pkg::EV_END, '0, arsp_pkg::ST_OK);
        add_row(1'b1, 8'hff, 1'b1, arsp_pkg::EV_END, '0, arsp_pkg::ST_EMPTY);
        for (int i = 0; i < 8; i++)
            add_row(1'b0, 8'hff, i == 7, arsp_pkg::EV_GEN, '1, arsp_pkg::ST_OK);
        add_row(1'b1, 8'h00, 1'b1, arsp_pkg::EV_END, '0, arsp_pkg::ST_OK);
        for (int i = 0; i < 8; i++)
            add_row(1'b0, 8'h00, i == 7, arsp_pkg::EV_GEN, '0, arsp_pkg::ST_OK);
        add_row(1'b0, 8'h80, 1'b0, arsp_pkg::EV_END, '0, arsp_pkg::ST_OK);
        add_row(1'b1, 8'h00, 1'b1, arsp_pkg::EV_END, '0, arsp_pkg::ST_TRUNC);
        foreach (directed_rows[i]) send_item(directed_rows[i]);

        // A long string while the receiver holds off, so that the core backs up.
        hold_req = 1'b1;
        push_field(file_q, {$urandom, $urandom});
        push_field(file_q, 64'h2a);
        push_field(file_q, 64'(arsp_pkg::REC_STR));
        push_field(file_q, 64'd40);
        repeat (40) push_byte(file_q, $urandom_range(255));
        push_end(file_q);
        send_file(file_q);

        for (int p = 0; p < 4; p++) begin
            case (p)
                0: lim = 30'd4;
                1: lim = 30'd0;
                2: lim = arsp_pkg::LimitReset;
                default: lim = 30'd7;
            endcase
            write_limit(lim);
            case (p)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 59; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 59; end
                default: begin gap_pct = 31; stall_pct = 31; end
            endcase
            target = useful_items + ITEMS_PER_PHASE;
            while (useful_items < target) begin
                file_q.delete();
                add_file(file_q, lim);
                send_file(file_q);
            end
        end

        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_events.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/arsp_pkg.sv
hw/rtl/arsp_in_stage.sv
hw/rtl/arsp_parser.sv
hw/rtl/arsp_out_stage.sv
hw/rtl/attribute_record_stream_parser_core.sv
test/tb_attribute_record_stream_parser_core.sv
